@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file lcbb_core_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ sv/lcbb_pkg.sv @@
// Types, constants and state codes for the byte-budget LRU frame cache.
// No dependencies.
package lcbb_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CHARGE_SHIFT = 4;
    localparam int PROD_W = 30;
    localparam int CHARGE_W = PROD_W + CHARGE_SHIFT;
    localparam int CAP_W = 40;
    localparam logic [CAP_W-1:0] CAP_RESET = 40'd1073741824;
    localparam int REMOVED_W = 5;
    localparam logic [REMOVED_W-1:0] REMOVED_MAX = 5'd31;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic [APB_ADDR_W-1:0] CAP_ADDR = 4'h0;

    typedef enum logic [1:0] {
        ACT_GET     = 2'd0,
        ACT_PUT     = 2'd1,
        ACT_CLR_REV = 2'd2,
        ACT_CLR_ALL = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_HIT,
        S_FULL,
        S_OLD,
        S_OLD_DROP,
        S_FREE,
        S_INS,
        S_TRIM,
        S_REV_RD,
        S_REV_CHK,
        S_CLR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_DROP,
        RK_HIT,
        RK_INS
    } rank_op_t;

    typedef struct packed {
        logic [63:0]         revision;
        logic [63:0]         seq_key;
        logic [63:0]         time_val;
        logic [61:0]         scale_dims;
        logic [63:0]         signature;
        logic [31:0]         handle;
        logic [CHARGE_W-1:0] bytes;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

@@ sv/lcbb_req_if.sv @@
// Request channel interface carrying one cache transaction.
// Depends on nothing.
interface lcbb_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [63:0]        key_revision;
    logic [63:0]        key_sequence;
    logic signed [63:0] key_time;
    logic [31:0]        key_timescale;
    logic [14:0]        key_width;
    logic [14:0]        key_height;
    logic [63:0]        key_signature;
    logic [31:0]        frame_handle;
    logic [14:0]        frame_width;
    logic [14:0]        frame_height;

    modport source (
        output valid, action, key_revision, key_sequence, key_time, key_timescale,
        key_width, key_height, key_signature, frame_handle, frame_width, frame_height,
        input  ready
    );
    modport sink (
        input  valid, action, key_revision, key_sequence, key_time, key_timescale,
        key_width, key_height, key_signature, frame_handle, frame_width, frame_height,
        output ready
    );
endinterface

@@ sv/lcbb_rsp_if.sv @@
// Response channel interface carrying one cache result transaction.
// Depends on nothing.
interface lcbb_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] found_handle;
    logic [39:0] total_bytes;
    logic [4:0]  removed_count;

    modport source (
        output valid, hit, found_handle, total_bytes, removed_count,
        input  ready
    );
    modport sink (
        input  valid, hit, found_handle, total_bytes, removed_count,
        output ready
    );
endinterface

@@ sv/lcbb_entry_mem.sv @@
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on lcbb_pkg.
module lcbb_entry_mem #(
    parameter int ENTRIES = lcbb_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  lcbb_pkg::mem_ctl_t          ctl,
    input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
    input  lcbb_pkg::entry_t            wr_data,
    output lcbb_pkg::entry_t            rd_data
);

    lcbb_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/lcbb_apb_cfg.sv @@
// APB register block holding the byte capacity.
// Depends on lcbb_pkg.
module lcbb_apb_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcbb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lcbb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcbb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [lcbb_pkg::CAP_W-1:0]          capacity
);

    logic [lcbb_pkg::CAP_W-1:0] cap_reg;
    logic                       cap_sel;

    assign cap_sel  = (paddr == lcbb_pkg::CAP_ADDR);
    assign pready   = 1'b1;
    assign prdata   = cap_sel ? lcbb_pkg::APB_DATA_W'(cap_reg) : '0;
    assign capacity = cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lcbb_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && cap_sel)
        begin
            cap_reg <= pwdata[lcbb_pkg::CAP_W-1:0];
        end
    end

endmodule

@@ sv/lcbb_ctrl.sv @@
// Sequencer for the cache: key search, LRU rank upkeep, insertion, eviction and clears.
// Depends on lcbb_pkg, lcbb_req_if, lcbb_rsp_if and lcbb_entry_mem.
module lcbb_ctrl #(
    parameter int ENTRIES = lcbb_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lcbb_pkg::CAP_W-1:0]  capacity,
    lcbb_req_if.sink                    req,
    lcbb_rsp_if.source                  rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int TOT_W = lcbb_pkg::CHARGE_W + CNT_W;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    lcbb_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    lcbb_pkg::entry_t   new_reg, new_next;
    lcbb_pkg::action_t  act_reg, act_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   rank_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOT_W-1:0]   bytes_reg, bytes_next;
    logic [lcbb_pkg::REMOVED_W-1:0] removed_reg, removed_next;
    logic               hit_reg, hit_next;
    logic [31:0]        found_reg, found_next;
    logic               trim_reg, trim_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [31:0]        out_found_reg, out_found_next;
    logic [39:0]        out_total_reg, out_total_next;
    logic [lcbb_pkg::REMOVED_W-1:0] out_removed_reg, out_removed_next;

    lcbb_pkg::mem_ctl_t mem_ctl;
    lcbb_pkg::entry_t   rd_data;
    logic [IDX_W-1:0]   idx_cur;
    logic               last;
    logic               key_match;
    logic               drop;
    logic               insert;
    lcbb_pkg::rank_op_t rank_op;
    logic [IDX_W-1:0]   rank_ref;
    logic [IDX_W-1:0]   rank_slot;
    logic [lcbb_pkg::PROD_W-1:0] prod;
    logic [lcbb_pkg::REMOVED_W-1:0] removed_inc;

    lcbb_entry_mem #(.ENTRIES(ENTRIES)) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (slot_reg),
        .rd_addr (idx_cur),
        .wr_data (new_reg),
        .rd_data (rd_data)
    );

    assign idx_cur   = idx_reg[IDX_W-1:0];
    assign last      = (idx_reg == LAST_IDX);
    assign req.ready = (state_reg == lcbb_pkg::S_IDLE);
    assign prod      = lcbb_pkg::PROD_W'(req.frame_width) * lcbb_pkg::PROD_W'(req.frame_height);
    assign removed_inc = (removed_reg == lcbb_pkg::REMOVED_MAX) ? removed_reg
                                                                : removed_reg + 1'b1;
    assign key_match = (rd_data.revision == new_reg.revision)
                    && (rd_data.seq_key == new_reg.seq_key)
                    && (rd_data.time_val == new_reg.time_val)
                    && (rd_data.scale_dims == new_reg.scale_dims)
                    && (rd_data.signature == new_reg.signature);

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.found_handle  = out_found_reg;
    assign rsp.total_bytes   = out_total_reg;
    assign rsp.removed_count = out_removed_reg;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        new_next     = new_reg;
        act_next     = act_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        bytes_next   = bytes_reg;
        removed_next = removed_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        trim_next    = trim_reg;
        mem_ctl      = '0;
        drop         = 1'b0;
        insert       = 1'b0;
        rank_op      = lcbb_pkg::RK_NONE;
        rank_ref     = rank_reg[idx_cur];
        rank_slot    = slot_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_hit_next     = out_hit_reg;
        out_found_next   = out_found_reg;
        out_total_next   = out_total_reg;
        out_removed_next = out_removed_reg;

        case (state_reg)
            lcbb_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next              = lcbb_pkg::action_t'(req.action);
                    new_next.revision     = req.key_revision;
                    new_next.seq_key      = req.key_sequence;
                    new_next.time_val     = req.key_time;
                    new_next.scale_dims   = {req.key_height, req.key_width, req.key_timescale};
                    new_next.signature    = req.key_signature;
                    new_next.handle       = req.frame_handle;
                    new_next.bytes        = {prod, {lcbb_pkg::CHARGE_SHIFT{1'b0}}};
                    idx_next              = '0;
                    removed_next          = '0;
                    hit_next              = 1'b0;
                    found_next            = '0;
                    case (lcbb_pkg::action_t'(req.action))
                        lcbb_pkg::ACT_GET:     state_next = lcbb_pkg::S_FIND_RD;
                        lcbb_pkg::ACT_PUT:     state_next = (req.frame_handle != '0)
                                                            ? lcbb_pkg::S_FIND_RD
                                                            : lcbb_pkg::S_DONE;
                        lcbb_pkg::ACT_CLR_REV: state_next = lcbb_pkg::S_REV_RD;
                        lcbb_pkg::ACT_CLR_ALL: state_next = lcbb_pkg::S_CLR;
                        default:               state_next = lcbb_pkg::S_DONE;
                    endcase
                end
            end
            lcbb_pkg::S_FIND_RD:
            begin
                if (valid_reg[idx_cur])
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = lcbb_pkg::S_FIND_CHK;
                end
                else if (last)
                begin
                    state_next = (act_reg == lcbb_pkg::ACT_GET) ? lcbb_pkg::S_DONE
                                                                : lcbb_pkg::S_FULL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lcbb_pkg::S_FIND_CHK:
            begin
                if (key_match)
                begin
                    slot_next = idx_cur;
                    if (act_reg == lcbb_pkg::ACT_GET)
                    begin
                        hit_next   = 1'b1;
                        found_next = rd_data.handle;
                        state_next = lcbb_pkg::S_HIT;
                    end
                    else
                    begin
                        drop       = 1'b1;
                        state_next = lcbb_pkg::S_FULL;
                    end
                end
                else if (last)
                begin
                    state_next = (act_reg == lcbb_pkg::ACT_GET) ? lcbb_pkg::S_DONE
                                                                : lcbb_pkg::S_FULL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = lcbb_pkg::S_FIND_RD;
                end
            end
            lcbb_pkg::S_HIT:
            begin
                rank_op    = lcbb_pkg::RK_HIT;
                rank_ref   = rank_reg[slot_reg];
                state_next = lcbb_pkg::S_DONE;
            end
            lcbb_pkg::S_FULL:
            begin
                idx_next   = '0;
                trim_next  = 1'b0;
                state_next = (count_reg == FULL_CNT) ? lcbb_pkg::S_OLD : lcbb_pkg::S_FREE;
            end
            lcbb_pkg::S_OLD:
            begin
                if (valid_reg[idx_cur] && (rank_reg[idx_cur] == IDX_W'(count_reg - 1'b1)))
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = lcbb_pkg::S_OLD_DROP;
                end
                else if (last)
                begin
                    state_next = lcbb_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lcbb_pkg::S_OLD_DROP:
            begin
                drop         = 1'b1;
                removed_next = removed_inc;
                idx_next     = '0;
                state_next   = trim_reg ? lcbb_pkg::S_TRIM : lcbb_pkg::S_FREE;
            end
            lcbb_pkg::S_FREE:
            begin
                if (!valid_reg[idx_cur])
                begin
                    slot_next  = idx_cur;
                    state_next = lcbb_pkg::S_INS;
                end
                else if (last)
                begin
                    state_next = lcbb_pkg::S_TRIM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lcbb_pkg::S_INS:
            begin
                mem_ctl.wr_en = 1'b1;
                insert        = 1'b1;
                rank_op       = lcbb_pkg::RK_INS;
                bytes_next    = bytes_reg + TOT_W'(new_reg.bytes);
                count_next    = count_reg + 1'b1;
                state_next    = lcbb_pkg::S_TRIM;
            end
            lcbb_pkg::S_TRIM:
            begin
                trim_next = 1'b1;
                idx_next  = '0;
                if ((64'(bytes_reg) > 64'(capacity)) && (count_reg != '0))
                begin
                    state_next = lcbb_pkg::S_OLD;
                end
                else
                begin
                    state_next = lcbb_pkg::S_DONE;
                end
            end
            lcbb_pkg::S_REV_RD:
            begin
                if (valid_reg[idx_cur])
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = lcbb_pkg::S_REV_CHK;
                end
                else if (last)
                begin
                    state_next = lcbb_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lcbb_pkg::S_REV_CHK:
            begin
                if (rd_data.revision == new_reg.revision)
                begin
                    drop         = 1'b1;
                    removed_next = removed_inc;
                end
                if (last)
                begin
                    state_next = lcbb_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = lcbb_pkg::S_REV_RD;
                end
            end
            lcbb_pkg::S_CLR:
            begin
                removed_next = (32'(count_reg) > 32'(lcbb_pkg::REMOVED_MAX))
                               ? lcbb_pkg::REMOVED_MAX
                               : lcbb_pkg::REMOVED_W'(count_reg);
                valid_next   = '0;
                count_next   = '0;
                bytes_next   = '0;
                state_next   = lcbb_pkg::S_DONE;
            end
            lcbb_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = hit_reg;
                    out_found_next   = found_reg;
                    out_total_next   = 40'(bytes_reg);
                    out_removed_next = removed_reg;
                    state_next       = lcbb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lcbb_pkg::S_IDLE;
            end
        endcase

        if (drop)
        begin
            valid_next[idx_cur] = 1'b0;
            bytes_next          = bytes_reg - TOT_W'(rd_data.bytes);
            count_next          = count_reg - 1'b1;
            rank_op             = lcbb_pkg::RK_DROP;
            rank_ref            = rank_reg[idx_cur];
        end
        if (insert)
        begin
            valid_next[slot_reg] = 1'b1;
        end

        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            case (rank_op)
                lcbb_pkg::RK_DROP:
                begin
                    if (valid_reg[i] && (rank_reg[i] > rank_ref))
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                lcbb_pkg::RK_HIT:
                begin
                    if (valid_reg[i] && (rank_reg[i] < rank_ref))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                lcbb_pkg::RK_INS:
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                default:
                begin
                    rank_next[i] = rank_reg[i];
                end
            endcase
        end
        if ((rank_op == lcbb_pkg::RK_HIT) || (rank_op == lcbb_pkg::RK_INS))
        begin
            rank_next[rank_slot] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcbb_pkg::S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        slot_reg        <= slot_next;
        new_reg         <= new_next;
        act_reg         <= act_next;
        removed_reg     <= removed_next;
        hit_reg         <= hit_next;
        found_reg       <= found_next;
        trim_reg        <= trim_next;
        out_hit_reg     <= out_hit_next;
        out_found_reg   <= out_found_next;
        out_total_reg   <= out_total_next;
        out_removed_reg <= out_removed_next;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

endmodule

@@ sv/lru_cache_with_byte_budget_core.sv @@
// Handles one transaction at a time: a new request is accepted only in idle, after the
// previous result has been loaded into the response register; each search walks the
// entry memory one slot after another.
// Reset (async, active low) empties the cache, zeroes the byte total and sets the
// capacity to 1 GiB; no clearing pass is needed.
module lru_cache_with_byte_budget_core #(
    parameter int ENTRIES = lcbb_pkg::ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lcbb_req_if.sink                            req,
    lcbb_rsp_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcbb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lcbb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcbb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [lcbb_pkg::CAP_W-1:0] capacity;

    lcbb_apb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    lcbb_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity),
        .req      (req),
        .rsp      (rsp)
    );

endmodule

@@ sv/lcbb_core_checker.sv @@
// Port-level checks on the cache result channel, bound to the top level.
// Depends on assert_macros.svh and lru_cache_with_byte_budget_core.
`include "assert_macros.svh"

module lcbb_core_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        hit,
    input logic [31:0] found_handle,
    input logic [4:0]  removed_count
);

    `ASSERT_IMP(a_hit_no_removal, clk, rst_n, rsp_valid && hit, removed_count == '0)
    `ASSERT_IMP(a_hit_has_handle, clk, rst_n, rsp_valid && hit, found_handle != '0)
    `ASSERT_IMP(a_miss_null_handle, clk, rst_n, rsp_valid && !hit, found_handle == '0)
    `ASSERT_NXT(a_stall_holds, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(found_handle))

endmodule

bind lru_cache_with_byte_budget_core lcbb_core_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .hit           (rsp.hit),
    .found_handle  (rsp.found_handle),
    .removed_count (rsp.removed_count)
);
